[rtl/core/lcu_pkg.sv]
// Package for the two-channel lux calculator: band codes, coefficients,
// default sizes and the elaboration-time fifth-root helper for the power ROM.
// No dependencies.
`timescale 1ns / 1ps

package lcu_pkg;

   localparam int DEF_COUNT_BITS  = 16;
   localparam int DEF_POW_ENTRIES = 256;
   localparam int QUEUE_DEPTH     = 4;

   localparam int IN_FIELD_BITS = 16;
   localparam int LUX_BITS      = 20;
   localparam int RATIO_BITS    = 16;
   localparam int POW_BITS      = 17;

   // Q0.24 coefficients, held in 20 bits
   localparam logic [19:0] K_BAND0_A = 20'd528482;
   localparam logic [19:0] K_BAND0_B = 20'd994889;
   localparam logic [19:0] K_BAND1_A = 20'd384198;
   localparam logic [19:0] K_BAND1_B = 20'd488217;
   localparam logic [19:0] K_BAND2_A = 20'd263402;
   localparam logic [19:0] K_BAND2_B = 20'd301990;
   localparam logic [19:0] K_BAND3_A = 20'd56707;
   localparam logic [19:0] K_BAND3_B = 20'd43621;

   localparam logic [LUX_BITS-1:0] INVALID_LUX_Q8 = 20'd255997;
   localparam logic [LUX_BITS-1:0] LUX_MAX        = 20'hFFFFF;

   typedef enum logic [2:0] {
      BAND_LOW     = 3'd0,
      BAND_MID     = 3'd1,
      BAND_HIGH    = 3'd2,
      BAND_TOP     = 3'd3,
      BAND_OVER    = 3'd4,
      BAND_INVALID = 3'd5
   } band_type;

   // largest z with z^5 <= target, z in 0..4096 (elaboration only)
   function automatic longint unsigned root5(input longint unsigned target);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lo = 0;
      hi = 4096;
      for (int k = 0; k < 13; k++) begin
         if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid * mid * mid * mid <= target) lo = mid;
            else hi = mid - 1;
         end
      end
      return lo;
   endfunction

endpackage

[rtl/core/two_channel_lux_calculator_unit.sv]
// Channel   | Dir | Fields
// req_      | in  | tdata: broadband_count[15:0], infrared_count[31:16]
// rsp_      | out | tdata: lux_q8[19:0]; tuser: band[2:0]
//
// One beat accepted per cycle while rsp_ is not stalled; the path from the
// accepting edge to rsp_tvalid runs through the front register, queue,
// 16-stage ratio divider, then ROM interpolation, multiply and output stages.
// Synchronous active-high reset clears all valid state; no clearing pass.
// A stall on rsp_ freezes the back pipeline; the front keeps taking beats
// until the four-entry queue fills. Depends on lcu_pkg and submodules.
`timescale 1ns / 1ps

module two_channel_lux_calculator_unit import lcu_pkg::*; #(
   parameter int COUNT_BITS          = DEF_COUNT_BITS,
   parameter int POWER_TABLE_ENTRIES = DEF_POW_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // broadband_count[15:0], infrared_count[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // lux_q8[19:0], zero pad [23:20]
   output logic [2:0]  rsp_tuser    // band[2:0]
);

   localparam int QW = 2 * COUNT_BITS + 3;

   logic                  push, full, pop, empty;
   logic [COUNT_BITS-1:0] f_bb, f_ir, q_bb, q_ir;
   band_type              f_band, q_band, o_band;
   logic [QW-1:0]         q_out;
   logic [LUX_BITS-1:0]   o_lux;

   lcu_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_bb      (req_tdata[COUNT_BITS-1:0]),
      .in_ir      (req_tdata[IN_FIELD_BITS+COUNT_BITS-1:IN_FIELD_BITS]),
      .push       (push),
      .queue_full (full),
      .out_bb     (f_bb),
      .out_ir     (f_ir),
      .out_band   (f_band)
   );

   lcu_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_band, f_ir, f_bb}),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (q_out)
   );

   assign q_bb   = q_out[COUNT_BITS-1:0];
   assign q_ir   = q_out[2*COUNT_BITS-1:COUNT_BITS];
   assign q_band = band_type'(q_out[QW-1:2*COUNT_BITS]);

   lcu_back #(
      .COUNT_BITS          (COUNT_BITS),
      .POWER_TABLE_ENTRIES (POWER_TABLE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!empty),
      .in_pop    (pop),
      .in_bb     (q_bb),
      .in_ir     (q_ir),
      .in_band   (q_band),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_lux   (o_lux),
      .out_band  (o_band)
   );

   assign rsp_tdata = {4'b0, o_lux};
   assign rsp_tuser = o_band;

endmodule

[rtl/core/lcu_front.sv]
// Front end: accepts a count pair, registers it and classifies the ratio band.
// Depends on lcu_pkg.
`timescale 1ns / 1ps

module lcu_front import lcu_pkg::*; #(
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COUNT_BITS-1:0] in_bb,
   input  logic [COUNT_BITS-1:0] in_ir,
   output logic                  push,
   input  logic                  queue_full,
   output logic [COUNT_BITS-1:0] out_bb,
   output logic [COUNT_BITS-1:0] out_ir,
   output band_type              out_band
);

   localparam int PW = COUNT_BITS + 8;

   logic                  vld_ff;
   logic [COUNT_BITS-1:0] bb_ff;
   logic [COUNT_BITS-1:0] ir_ff;
   logic [PW-1:0]         ir100, bb52, bb65, bb80, bb130;

   assign push     = vld_ff && !queue_full;
   assign in_ready = !vld_ff || !queue_full;

   // hold one beat
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (in_ready) vld_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         bb_ff <= in_bb;
         ir_ff <= in_ir;
      end
   end

   // exact band compares against scaled broadband count
   always_comb begin
      ir100 = PW'(ir_ff) * PW'(100);
      bb52  = PW'(bb_ff) * PW'(52);
      bb65  = PW'(bb_ff) * PW'(65);
      bb80  = PW'(bb_ff) * PW'(80);
      bb130 = PW'(bb_ff) * PW'(130);
      if (bb_ff == '0 && ir_ff == '0) out_band = BAND_INVALID;
      else if (ir100 <= bb52)         out_band = BAND_LOW;
      else if (ir100 <= bb65)         out_band = BAND_MID;
      else if (ir100 <= bb80)         out_band = BAND_HIGH;
      else if (ir100 <= bb130)        out_band = BAND_TOP;
      else                            out_band = BAND_OVER;
   end

   assign out_bb = bb_ff;
   assign out_ir = ir_ff;

endmodule

[rtl/core/lcu_queue.sv]
// Small register FIFO between the front end and the back end.
// Depends on lcu_pkg.
`timescale 1ns / 1ps

module lcu_queue import lcu_pkg::*; #(
   parameter int WIDTH = 35
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:QUEUE_DEPTH-1];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_pop;

   assign full     = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push)   wr_ff <= PTR_W'(wr_ff + 1'b1);
         if (do_pop) rd_ff <= PTR_W'(rd_ff + 1'b1);
         if (push && !do_pop)      cnt_ff <= CNT_W'(cnt_ff + 1'b1);
         else if (!push && do_pop) cnt_ff <= CNT_W'(cnt_ff - 1'b1);
      end
   end

endmodule

[rtl/core/lcu_back.sv]
// Back end: pipelined ratio divider, power ROM interpolation, band formulas
// and output register. Whole pipeline advances together. Depends on lcu_pkg.
`timescale 1ns / 1ps

module lcu_back import lcu_pkg::*; #(
   parameter int COUNT_BITS          = DEF_COUNT_BITS,
   parameter int POWER_TABLE_ENTRIES = DEF_POW_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_pop,
   input  logic [COUNT_BITS-1:0] in_bb,
   input  logic [COUNT_BITS-1:0] in_ir,
   input  band_type              in_band,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [LUX_BITS-1:0]   out_lux,
   output band_type              out_band
);

   localparam int CB    = COUNT_BITS;
   localparam int E     = POWER_TABLE_ENTRIES;
   localparam int AW    = 20 + CB;
   localparam int MW    = 20 + CB;
   localparam int BW    = MW + 1;
   localparam int IDX_W = $clog2(E + 1);
   localparam int S_W   = RATIO_BITS + IDX_W;
   localparam int ND    = RATIO_BITS;
   localparam int ML_W  = 18;
   localparam int MH_W  = MW - ML_W;

   logic adv;
   logic o_vld_ff;

   // power ROM built at elaboration: entry i = (i/E)^1.4 in Q1.16
   logic [POW_BITS-1:0] pow_rom [0:E];
   for (genvar i = 0; i <= E; i++) begin : g_rom
      localparam longint unsigned Q   = (longint'(i) << 30) / E;
      localparam longint unsigned Z   = root5(Q * Q);
      localparam longint unsigned ENT =
         (longint'(i) * Z * 65536 + longint'(E) * 2048) / (longint'(E) * 4096);
      assign pow_rom[i] = POW_BITS'(ENT);
   end

   // divider stages
   logic          dv_vld_ff  [0:ND];
   logic [CB-1:0] dv_bb_ff   [0:ND];
   band_type      dv_band_ff [0:ND];
   logic [AW-1:0] dv_a_ff    [0:ND];
   logic [MW-1:0] dv_m_ff    [0:ND];
   logic [CB-1:0] dv_rem_ff  [0:ND];
   logic [ND-1:0] dv_quo_ff  [0:ND];

   logic [19:0] coef_a, coef_m;
   logic [CB-1:0] mul_src;

   assign out_valid = o_vld_ff;
   assign adv       = !o_vld_ff || out_ready;
   assign in_pop    = adv;

   // coefficient pick
   always_comb begin
      case (in_band)
         BAND_LOW:  begin coef_a = K_BAND0_A; coef_m = K_BAND0_B; mul_src = in_bb; end
         BAND_MID:  begin coef_a = K_BAND1_A; coef_m = K_BAND1_B; mul_src = in_ir; end
         BAND_HIGH: begin coef_a = K_BAND2_A; coef_m = K_BAND2_B; mul_src = in_ir; end
         default:   begin coef_a = K_BAND3_A; coef_m = K_BAND3_B; mul_src = in_ir; end
      endcase
   end

   // stage 0: load and multiply coefficients
   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else if (adv) dv_vld_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_bb_ff[0]   <= in_bb;
         dv_band_ff[0] <= in_band;
         dv_a_ff[0]    <= AW'(coef_a) * AW'(in_bb);
         dv_m_ff[0]    <= MW'(coef_m) * MW'(mul_src);
         dv_rem_ff[0]  <= in_ir;
         dv_quo_ff[0]  <= '0;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < ND; k++) begin : g_div
      logic [CB:0] sh;
      logic        ge;
      assign sh = {dv_rem_ff[k], 1'b0};
      assign ge = sh >= {1'b0, dv_bb_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[k+1] <= 1'b0;
         else if (adv) dv_vld_ff[k+1] <= dv_vld_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_bb_ff[k+1]   <= dv_bb_ff[k];
            dv_band_ff[k+1] <= dv_band_ff[k];
            dv_a_ff[k+1]    <= dv_a_ff[k];
            dv_m_ff[k+1]    <= dv_m_ff[k];
            dv_rem_ff[k+1]  <= ge ? CB'(sh - {1'b0, dv_bb_ff[k]}) : CB'(sh);
            dv_quo_ff[k+1]  <= {dv_quo_ff[k][ND-2:0], ge};
         end
      end
   end

   // post-divider stages
   logic                 s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;
   band_type             s1_band_ff, s2_band_ff, s3_band_ff, s4_band_ff, s5_band_ff;
   band_type             s6_band_ff, o_band_ff;
   logic [AW-1:0]        s1_a_ff, s2_a_ff, s3_a_ff, s4_a_ff, s5_a_ff, s6_a_ff;
   logic [MW-1:0]        s1_m_ff, s2_m_ff, s3_m_ff, s4_m_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic [15:0]          s1_f_ff, s2_f_ff;
   logic [POW_BITS-1:0]  s2_t0_ff, s3_t0_ff, s2_dt_ff, s4_p_ff;
   logic [POW_BITS+15:0] s3_prod_ff;
   logic [ML_W+POW_BITS-1:0] s5_pl_ff;
   logic [MH_W+POW_BITS-1:0] s5_ph_ff;
   logic [MW-1:0]        s5_m_ff;
   logic [BW-1:0]        s6_b_ff;
   logic [LUX_BITS-1:0]  o_lux_ff;

   logic [S_W-1:0]       s_prod;
   logic [IDX_W-1:0]     idx_n, idx_p1;
   logic [15:0]          f_n;
   logic [POW_BITS-1:0]  t0_n, t1_n;
   logic [POW_BITS+15:0] rnd_n;
   logic [MW+POW_BITS:0] sum_n;
   logic [BW:0]          diff_n;
   logic [AW:0]          v_n;
   logic [LUX_BITS-1:0]  lux_n;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0; s2_vld_ff <= 1'b0; s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0; s5_vld_ff <= 1'b0; s6_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= dv_vld_ff[ND];
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         o_vld_ff  <= s6_vld_ff;
      end
   end

   // table index and fraction
   always_comb begin
      s_prod = S_W'(dv_quo_ff[ND]) * S_W'(E);
      idx_n  = s_prod[S_W-1:16];
      f_n    = s_prod[15:0];
      if (idx_n >= IDX_W'(E)) begin
         idx_n = IDX_W'(E);
         f_n   = '0;
      end
   end

   // ROM read
   always_comb begin
      idx_p1 = (s1_idx_ff == IDX_W'(E)) ? s1_idx_ff : IDX_W'(s1_idx_ff + 1'b1);
      t0_n   = pow_rom[s1_idx_ff];
      t1_n   = (s1_f_ff != '0) ? pow_rom[idx_p1] : t0_n;
      if (t1_n < t0_n) t1_n = t0_n;
   end

   assign rnd_n = s3_prod_ff + (POW_BITS+16)'(32768);
   assign sum_n = ((MW+POW_BITS+1)'(s5_ph_ff) << ML_W) + (MW+POW_BITS+1)'(s5_pl_ff)
                  + (MW+POW_BITS+1)'(32768);

   // final formula with clamp, saturation and band overrides
   always_comb begin
      diff_n = (BW+1)'(s6_a_ff) - (BW+1)'(s6_b_ff);
      v_n    = (AW+1)'((diff_n + (BW+1)'(32768)) >> 16);
      lux_n  = (v_n > (AW+1)'(LUX_MAX)) ? LUX_MAX : v_n[LUX_BITS-1:0];
      if ((AW+1)'(s6_b_ff) >= (AW+1)'(s6_a_ff)) lux_n = '0;
      case (s6_band_ff)
         BAND_INVALID: lux_n = INVALID_LUX_Q8;
         BAND_OVER:    lux_n = '0;
         default:      ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_band_ff <= dv_band_ff[ND];
         s1_a_ff    <= dv_a_ff[ND];
         s1_m_ff    <= dv_m_ff[ND];
         s1_idx_ff  <= idx_n;
         s1_f_ff    <= f_n;

         s2_band_ff <= s1_band_ff;
         s2_a_ff    <= s1_a_ff;
         s2_m_ff    <= s1_m_ff;
         s2_f_ff    <= s1_f_ff;
         s2_t0_ff   <= t0_n;
         s2_dt_ff   <= t1_n - t0_n;

         s3_band_ff <= s2_band_ff;
         s3_a_ff    <= s2_a_ff;
         s3_m_ff    <= s2_m_ff;
         s3_t0_ff   <= s2_t0_ff;
         s3_prod_ff <= (POW_BITS+16)'(s2_dt_ff) * (POW_BITS+16)'(s2_f_ff);

         s4_band_ff <= s3_band_ff;
         s4_a_ff    <= s3_a_ff;
         s4_m_ff    <= s3_m_ff;
         s4_p_ff    <= POW_BITS'(s3_t0_ff + POW_BITS'(rnd_n >> 16));

         s5_band_ff <= s4_band_ff;
         s5_a_ff    <= s4_a_ff;
         s5_m_ff    <= s4_m_ff;
         s5_pl_ff   <= (ML_W+POW_BITS)'(s4_m_ff[ML_W-1:0]) * (ML_W+POW_BITS)'(s4_p_ff);
         s5_ph_ff   <= (MH_W+POW_BITS)'(s4_m_ff[MW-1:ML_W]) * (MH_W+POW_BITS)'(s4_p_ff);

         s6_band_ff <= s5_band_ff;
         s6_a_ff    <= s5_a_ff;
         s6_b_ff    <= (s5_band_ff == BAND_LOW) ? BW'(sum_n >> 16) : BW'(s5_m_ff);

         o_band_ff  <= s6_band_ff;
         o_lux_ff   <= lux_n;
      end
   end

   assign out_lux  = o_lux_ff;
   assign out_band = o_band_ff;

endmodule

[rtl/core/lcu_checker.sv]
// Port-level checker for the lux calculator, bound to the top level.
// Depends on lcu_pkg and two_channel_lux_calculator_unit.
`timescale 1ns / 1ps

module lcu_checker import lcu_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // stalled result beat stays up
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped under stall");

   // stalled result beat holds its payload
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed under stall");

   a_band_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= BAND_INVALID)
      else $error("band code out of range");

   a_over_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == BAND_OVER |-> rsp_tdata == 24'd0)
      else $error("lux nonzero above ratio limit");

   a_invalid_sentinel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == BAND_INVALID |-> rsp_tdata[19:0] == INVALID_LUX_Q8)
      else $error("invalid beat without sentinel");

endmodule

bind two_channel_lux_calculator_unit lcu_checker u_lcu_checker (.*);

[tb/tb.sv]
// Self-checking bench for two_channel_lux_calculator_unit: random and directed
// count pairs with a scoreboard class that predicts lux and band per beat.
// Depends on lcu_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb;
   import lcu_pkg::*;

   typedef struct {
      logic [LUX_BITS-1:0] lux;
      band_type            band;
   } lux_result_type;

   // predicts illuminance from count pairs and matches results in order
   class lux_scoreboard_type;
      longint unsigned pow_rom[DEF_POW_ENTRIES+1];
      lux_result_type  pending[$];
      int              errors;

      function new();
         longint unsigned e, q, tgt, lo, hi, mid;
         e = DEF_POW_ENTRIES;
         errors = 0;
         // (i/E)^1.4 in Q1.16 via integer fifth root of q^2
         for (int i = 0; i <= DEF_POW_ENTRIES; i++) begin
            q = (longint'(i) << 30) / e;
            tgt = q * q;
            lo = 0;
            hi = 4096;
            while (lo < hi) begin
               mid = (lo + hi + 1) >> 1;
               if (mid * mid * mid * mid * mid <= tgt) lo = mid;
               else hi = mid - 1;
            end
            pow_rom[i] = (longint'(i) * lo * 65536 + ((e * 4096) >> 1)) / (e * 4096);
         end
      endfunction

      function longint unsigned interp_pow(longint unsigned r);
         longint unsigned s, idx, f, t0, t1;
         s = r * DEF_POW_ENTRIES;
         idx = s >> 16;
         f = s & 64'hFFFF;
         if (idx >= DEF_POW_ENTRIES) begin
            idx = DEF_POW_ENTRIES;
            f = 0;
         end
         t0 = pow_rom[idx];
         t1 = (f != 0) ? pow_rom[idx+1] : t0;
         if (t1 < t0) t1 = t0;
         return t0 + (((t1 - t0) * f + 32768) >> 16);
      endfunction

      function logic [LUX_BITS-1:0] clamp_lux(longint unsigned a, longint unsigned b);
         longint unsigned v;
         if (b >= a) return '0;
         v = (a - b + 32768) >> 16;
         return (v > LUX_MAX) ? LUX_MAX : v[LUX_BITS-1:0];
      endfunction

      function void note_pair(logic [15:0] bb16, logic [15:0] ir16);
         longint unsigned bb, ir, p;
         lux_result_type  x;
         bb = bb16;
         ir = ir16;
         if (bb == 0 && ir == 0) begin
            x.lux = INVALID_LUX_Q8;
            x.band = BAND_INVALID;
         end else if (100 * ir <= 52 * bb) begin
            p = interp_pow((ir << 16) / bb);
            x.lux = clamp_lux(K_BAND0_A * bb, (K_BAND0_B * bb * p + 32768) >> 16);
            x.band = BAND_LOW;
         end else if (100 * ir <= 65 * bb) begin
            x.lux = clamp_lux(K_BAND1_A * bb, K_BAND1_B * ir);
            x.band = BAND_MID;
         end else if (100 * ir <= 80 * bb) begin
            x.lux = clamp_lux(K_BAND2_A * bb, K_BAND2_B * ir);
            x.band = BAND_HIGH;
         end else if (100 * ir <= 130 * bb) begin
            x.lux = clamp_lux(K_BAND3_A * bb, K_BAND3_B * ir);
            x.band = BAND_TOP;
         end else begin
            x.lux = '0;
            x.band = BAND_OVER;
         end
         pending.push_back(x);
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_beat(logic [23:0] data, logic [2:0] user);
         lux_result_type x;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected beat lux=%0d band=%0d",
                                      data[19:0], user));
            return;
         end
         x = pending.pop_front();
         if (data[19:0] !== x.lux)
            report_mismatch($sformatf("lux %0d, want %0d", data[19:0], x.lux));
         if (data[23:20] !== 4'd0)
            report_mismatch($sformatf("pad bits %h not zero", data[23:20]));
         if (user !== x.band)
            report_mismatch($sformatf("band %0d, want %0d", user, x.band));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // broadband_count[15:0], infrared_count[31:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // lux_q8[19:0], zero pad [23:20]
   logic [2:0]  rsp_tuser;    // band[2:0]

   lux_scoreboard_type sb;
   int                 results_seen;
   bit                 sender_done;

   two_channel_lux_calculator_unit uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // offer one pair, hold it until accepted
   task automatic send_pair(logic [15:0] bb, logic [15:0] ir, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ir, bb};
      do @(posedge clock); while (!req_tready);
      sb.note_pair(bb, ir);
   endtask

   // pair with ir near a chosen percentage of bb
   task automatic send_ratio_pair(int gap);
      logic [15:0] bb;
      int unsigned pct;
      longint      ir;
      bb  = 16'($urandom_range(1, 65535));
      if ($urandom_range(0, 3) == 0) bb = 16'($urandom_range(1, 300));
      pct = $urandom_range(0, 140);
      ir  = (longint'(bb) * pct) / 100 + $signed($urandom_range(0, 2)) - 1;
      if (ir < 0) ir = 0;
      if (ir > 65535) ir = 65535;
      send_pair(bb, ir[15:0], gap);
   endtask

   // stimulus
   initial begin
      int gap;
      sb = new();
      sender_done = 0;
      req_tvalid = 0;
      req_tdata  = '0;
      reset = 1;
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: invalid, zero broadband, extremes and band edges
      send_pair(16'd0, 16'd0, 0);
      send_pair(16'd0, 16'd5, 0);
      send_pair(16'd0, 16'hFFFF, 1);
      send_pair(16'hFFFF, 16'd0, 0);
      send_pair(16'hFFFF, 16'hFFFF, 0);
      send_pair(16'd1, 16'd0, 2);
      send_pair(16'd1, 16'd1, 0);
      send_pair(16'd100, 16'd52, 0);
      send_pair(16'd100, 16'd53, 0);
      send_pair(16'd100, 16'd65, 0);
      send_pair(16'd100, 16'd66, 0);
      send_pair(16'd100, 16'd80, 3);
      send_pair(16'd100, 16'd81, 0);
      send_pair(16'd100, 16'd130, 0);
      send_pair(16'd100, 16'd131, 0);
      send_pair(16'd50000, 16'd26000, 0);
      send_pair(16'd40000, 16'd31999, 0);
      send_pair(16'd20000, 16'd25999, 0);
      send_pair(16'hAAAA, 16'h5555, 0);
      send_pair(16'h5555, 16'h2AAA, 0);

      for (int n = 0; n < 1500; n++) begin
         gap = $urandom_range(0, 6);
         if (n >= 400 && n < 600) gap = 0;
         // drain completely once mid-run
         if (n == 800) begin
            req_tvalid <= 1'b0;
            while (sb.pending.size() != 0) @(posedge clock);
            gap = 0;
         end
         if ($urandom_range(0, 2) == 0)
            send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), gap);
         else if ($urandom_range(0, 30) == 0)
            send_pair($urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 65535)),
                      16'd0, gap);
         else
            send_ratio_pair(gap);
      end
      req_tvalid <= 1'b0;
      sender_done = 1;
   end

   // result side
   initial begin
      int stall;
      results_seen = 0;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_beat(rsp_tdata, rsp_tuser);
         results_seen++;
         stall = $urandom_range(0, 6);
         if (results_seen >= 400 && results_seen < 600) stall = 0;
         if (results_seen == 300) stall = 200;   // long hold-off, input backs up
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // end of run
   initial begin
      @(negedge reset);
      wait (sender_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
